[rtl/core/btda_pkg.sv]
// shared types and constants for the binary to decimal ascii converter
package btda_pkg;

    localparam logic [5:0] ASCII_ZERO  = 6'd48;
    localparam logic [3:0] DABBLE_MIN  = 4'd5;
    localparam logic [3:0] DABBLE_ADD  = 4'd3;
    localparam logic [3:0] DIGIT_ZERO  = 4'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } btda_state_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } btda_ctl_t;

endpackage

[rtl/core/binary_to_decimal_ascii_top.sv]
// binary to decimal ascii converter top level with sequencing fsm
//
// channel | handshake            | payload
// bin     | bin_valid, bin_stall | value
// dig     | dig_valid, dig_stall | digit_char, last
//
// after the accepting edge the value is shifted in bit by bit, one conversion step per input bit
// then leading zero digits are skipped, the skip phase is left, and the remaining digits are sent
// skipped and sent digits together make MAX_DIGITS
// digits leave through a single output register, a stall holds the sequencer in the send phase
// a new value is taken once the last digit sits in the output register
// reset clears the fsm, its counters and the output valid only
module binary_to_decimal_ascii_top
    import btda_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        bin_valid,
    output logic        bin_stall,
    input  logic [63:0] value,
    output logic        dig_valid,
    input  logic        dig_stall,
    output logic [5:0]  digit_char,
    output logic        last
);

    localparam int CNT_W  = $clog2(VALUE_BITS);
    localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

    btda_state_t       state_reg;
    btda_state_t       state_next;
    logic [CNT_W-1:0]  bit_cnt_reg;
    logic [CNT_W-1:0]  bit_cnt_next;
    logic [DCNT_W-1:0] dig_cnt_reg;
    logic [DCNT_W-1:0] dig_cnt_next;
    btda_ctl_t         ctl;
    logic [3:0]        top_digit;
    logic              free;
    logic              emit_load;
    logic              dig_one;

    assign dig_one   = (dig_cnt_reg == DCNT_W'(1));
    assign bin_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        ctl          = '0;
        emit_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (bin_valid)
                begin
                    ctl.load     = 1'b1;
                    bit_cnt_next = CNT_W'(VALUE_BITS - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctl.dabble   = 1'b1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DCNT_W'(MAX_DIGITS);
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == DIGIT_ZERO && !dig_one)
                begin
                    ctl.shift    = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (free)
                begin
                    emit_load    = 1'b1;
                    ctl.shift    = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (dig_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    btda_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .clk       (clk),
        .ctl       (ctl),
        .bin       (value[VALUE_BITS-1:0]),
        .top_digit (top_digit)
    );

    btda_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit_load),
        .digit      (top_digit),
        .last_in    (dig_one),
        .free       (free),
        .dig_valid  (dig_valid),
        .dig_stall  (dig_stall),
        .digit_char (digit_char),
        .last       (last)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_load && dig_one |=> state_reg == ST_IDLE && dig_valid && last)
        else $error("last digit did not end the run");

    assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> digit_char >= 6'd48 && digit_char <= 6'd57)
        else $error("digit out of decimal range");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SKIP || state_reg == ST_EMIT |-> dig_cnt_reg != '0)
        else $error("digit count ran out while sending");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit_load && !dig_one |=> state_reg == ST_EMIT)
        else $error("run ended before its last digit");
`endif

endmodule

[rtl/core/btda_dabble.sv]
// bit-serial double dabble: binary shift register and bcd digit register
module btda_dabble
    import btda_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 20
)
(
    input  logic                  clk,
    input  btda_ctl_t             ctl,
    input  logic [VALUE_BITS-1:0] bin,
    output logic [3:0]            top_digit
);

    localparam int BCD_W = 4 * MAX_DIGITS;

    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [BCD_W-1:0]      adj;

    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= DABBLE_MIN)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + DABBLE_ADD;
            end
            else
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctl.load)
        begin
            bin_next = bin;
            bcd_next = '0;
        end
        else if (ctl.dabble)
        begin
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
        end
        else if (ctl.shift)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], DIGIT_ZERO};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

[rtl/core/btda_emit.sv]
// output register for digit transactions
module btda_emit
    import btda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [3:0] digit,
    input  logic       last_in,
    output logic       free,
    output logic       dig_valid,
    input  logic       dig_stall,
    output logic [5:0] digit_char,
    output logic       last
);

    logic       valid_reg;
    logic       valid_next;
    logic [5:0] char_reg;
    logic       last_reg;

    assign free = !valid_reg || !dig_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!dig_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= ASCII_ZERO + {2'b00, digit};
            last_reg <= last_in;
        end
    end

    assign dig_valid  = valid_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

endmodule
